// ===== rtl/bqc_pkg.sv =====
// ----------------------------------------------------------------------------
// bqc_pkg - shared definitions for the biquad cascade filter
// Control word layout, microcode program, register indexes and default values.
// ----------------------------------------------------------------------------
package bqc_pkg;

	// default widths
	localparam int SAMPLE_WIDTH_DEF = 24;
	localparam int DELAY_WIDTH_DEF  = 40;
	localparam int COEF_WIDTH_DEF   = 18;
	localparam int COEF_WIDTH_MAX   = 25;

	// fraction bits of coefficients and delay words
	localparam int Q_COEF  = 15;
	localparam int Q_DELAY = 12;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_SEC0_FB1 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEC0_FB2 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEC0_NUM = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SEC1_FB1 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SEC1_FB2 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SEC1_NUM = 3'd5;

	// register defaults (low-pass), wide enough for the largest field width
	localparam int RST_W = 3 * COEF_WIDTH_MAX;
	localparam logic [RST_W-1:0] RST_SEC0_FB1 = RST_W'(-22044);
	localparam logic [RST_W-1:0] RST_SEC0_FB2 = RST_W'(4736);
	localparam logic [RST_W-1:0] RST_SEC0_NUM = RST_W'(64'd41781760885344);
	localparam logic [RST_W-1:0] RST_SEC1_FB1 = RST_W'(-29415);
	localparam logic [RST_W-1:0] RST_SEC1_FB2 = RST_W'(17275);
	localparam logic [RST_W-1:0] RST_SEC1_NUM = RST_W'(64'd2251816993587200);

	// control word fields
	typedef enum logic [2:0] {
		COEF_A1,
		COEF_A2,
		COEF_B0,
		COEF_B1,
		COEF_B2
	} coef_sel_t;

	typedef enum logic [1:0] {
		OPND_W1,
		OPND_W2,
		OPND_W
	} opnd_sel_t;

	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_LOAD_IN,
		ACC_SUB,
		ACC_ADD,
		ACC_LOAD_P
	} acc_op_t;

	typedef enum logic {
		SEQ_NEXT,
		SEQ_SEC_END
	} seq_op_t;

	typedef struct packed {
		coef_sel_t coef;
		opnd_sel_t opnd;
		logic      mul_hi;
		acc_op_t   acc_op;
		logic      wr_w;
		seq_op_t   seq_op;
	} ucw_t;

	typedef logic [3:0] upc_t;
	localparam upc_t UPC_LAST = 4'd11;

	// control from the sequencer to the datapath
	typedef struct packed {
		logic run;
		logic sec;
		logic emit;
		ucw_t cw;
	} bqc_ctl_t;

	// Program for one section. The multiply of step k is accumulated in
	// step k+1; the delay word is split into a low and a high half.
	function automatic ucw_t ucode_rom(input upc_t pc);
		ucw_t cw;
		unique case (pc)
			4'd0:  cw = '{COEF_A1, OPND_W1, 1'b0, ACC_LOAD_IN, 1'b0, SEQ_NEXT};
			4'd1:  cw = '{COEF_A1, OPND_W1, 1'b1, ACC_SUB,     1'b0, SEQ_NEXT};
			4'd2:  cw = '{COEF_A2, OPND_W2, 1'b0, ACC_SUB,     1'b0, SEQ_NEXT};
			4'd3:  cw = '{COEF_A2, OPND_W2, 1'b1, ACC_SUB,     1'b0, SEQ_NEXT};
			4'd4:  cw = '{COEF_B1, OPND_W1, 1'b0, ACC_SUB,     1'b0, SEQ_NEXT};
			4'd5:  cw = '{COEF_B1, OPND_W1, 1'b1, ACC_LOAD_P,  1'b1, SEQ_NEXT};
			4'd6:  cw = '{COEF_B2, OPND_W2, 1'b0, ACC_ADD,     1'b0, SEQ_NEXT};
			4'd7:  cw = '{COEF_B2, OPND_W2, 1'b1, ACC_ADD,     1'b0, SEQ_NEXT};
			4'd8:  cw = '{COEF_B0, OPND_W,  1'b0, ACC_ADD,     1'b0, SEQ_NEXT};
			4'd9:  cw = '{COEF_B0, OPND_W,  1'b1, ACC_ADD,     1'b0, SEQ_NEXT};
			4'd10: cw = '{COEF_B0, OPND_W,  1'b0, ACC_ADD,     1'b0, SEQ_NEXT};
			4'd11: cw = '{COEF_B0, OPND_W,  1'b0, ACC_HOLD,    1'b0, SEQ_SEC_END};
			default: cw = '{COEF_B0, OPND_W, 1'b0, ACC_HOLD,   1'b0, SEQ_SEC_END};
		endcase
		return cw;
	endfunction

endpackage

// ===== rtl/iir_biquad_cascade_filter_top.sv =====
// ----------------------------------------------------------------------------
// iir_biquad_cascade_filter_top - two cascaded direct-form-II biquads
// A new input word is taken only while the sequencer is idle: the twelve-step
// program runs once per section on the single shared multiplier, and its last
// step holds while the output register is still full.
// Reset clears the delay words and the output valid flag and loads the default
// low-pass coefficients.
// ----------------------------------------------------------------------------
module iir_biquad_cascade_filter_top #(
	parameter int SAMPLE_WIDTH = bqc_pkg::SAMPLE_WIDTH_DEF,
	parameter int DELAY_WIDTH  = bqc_pkg::DELAY_WIDTH_DEF,
	parameter int COEF_WIDTH   = bqc_pkg::COEF_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [SAMPLE_WIDTH-1:0]       sample_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [SAMPLE_WIDTH-1:0]       sample_out,
	input  logic                          cfg_we,
	input  logic [bqc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [3*COEF_WIDTH-1:0]       cfg_data
);
	import bqc_pkg::*;

	logic                         busy;
	logic                         start;
	bqc_ctl_t                     ctl;
	logic [1:0][COEF_WIDTH-1:0]   fb1;
	logic [1:0][COEF_WIDTH-1:0]   fb2;
	logic [1:0][3*COEF_WIDTH-1:0] num;
	logic [SAMPLE_WIDTH-1:0]      y;
	logic                         out_valid_q;
	logic [SAMPLE_WIDTH-1:0]      sample_out_q;

	assign in_stall = busy;
	assign start    = in_valid && !in_stall;

	bqc_regs #(
		.COEF_WIDTH (COEF_WIDTH)
	) u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fb1       (fb1),
		.fb2       (fb2),
		.num       (num)
	);

	bqc_useq u_useq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.out_blocked (out_valid_q && out_stall),
		.busy        (busy),
		.ctl         (ctl)
	);

	bqc_datapath #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.DELAY_WIDTH  (DELAY_WIDTH),
		.COEF_WIDTH   (COEF_WIDTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.load   (start),
		.sample (sample_in),
		.fb1    (fb1),
		.fb2    (fb2),
		.num    (num),
		.y      (y)
	);

	// output word register: load on result, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			sample_out_q <= y;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

`ifndef NO_ASSERTIONS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> !(out_valid_q && out_stall))
		else $error("result overwrote a waiting output word");
`endif

endmodule

// ===== rtl/bqc_regs.sv =====
// ----------------------------------------------------------------------------
// bqc_regs - coefficient registers
// Six write-only registers, loaded with the low-pass defaults at reset.
// ----------------------------------------------------------------------------
module bqc_regs #(
	parameter int COEF_WIDTH = bqc_pkg::COEF_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [bqc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [3*COEF_WIDTH-1:0]            cfg_data,
	output logic [1:0][COEF_WIDTH-1:0]         fb1,
	output logic [1:0][COEF_WIDTH-1:0]         fb2,
	output logic [1:0][3*COEF_WIDTH-1:0]       num
);
	import bqc_pkg::*;

	logic [1:0][COEF_WIDTH-1:0]   fb1_q;
	logic [1:0][COEF_WIDTH-1:0]   fb2_q;
	logic [1:0][3*COEF_WIDTH-1:0] num_q;

	// decode the index and write; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb1_q[0] <= RST_SEC0_FB1[COEF_WIDTH-1:0];
			fb2_q[0] <= RST_SEC0_FB2[COEF_WIDTH-1:0];
			num_q[0] <= RST_SEC0_NUM[3*COEF_WIDTH-1:0];
			fb1_q[1] <= RST_SEC1_FB1[COEF_WIDTH-1:0];
			fb2_q[1] <= RST_SEC1_FB2[COEF_WIDTH-1:0];
			num_q[1] <= RST_SEC1_NUM[3*COEF_WIDTH-1:0];
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SEC0_FB1: fb1_q[0] <= cfg_data[COEF_WIDTH-1:0];
				REG_SEC0_FB2: fb2_q[0] <= cfg_data[COEF_WIDTH-1:0];
				REG_SEC0_NUM: num_q[0] <= cfg_data;
				REG_SEC1_FB1: fb1_q[1] <= cfg_data[COEF_WIDTH-1:0];
				REG_SEC1_FB2: fb2_q[1] <= cfg_data[COEF_WIDTH-1:0];
				REG_SEC1_NUM: num_q[1] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign fb1 = fb1_q;
	assign fb2 = fb2_q;
	assign num = num_q;

endmodule

// ===== rtl/bqc_useq.sv =====
// ----------------------------------------------------------------------------
// bqc_useq - microcode sequencer
// Steps through the section program twice per word and drives the datapath.
// ----------------------------------------------------------------------------
module bqc_useq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              out_blocked,
	output logic              busy,
	output bqc_pkg::bqc_ctl_t ctl
);
	import bqc_pkg::*;

	logic busy_q, busy_d;
	upc_t pc_q, pc_d;
	logic sec_q, sec_d;
	ucw_t cw;
	logic last;
	logic run;

	// fetch the control word
	assign cw   = ucode_rom(pc_q);
	assign last = (cw.seq_op == SEQ_SEC_END) && sec_q;
	// hold on the last step while the output register is still full
	assign run  = busy_q && !(last && out_blocked);

	// next step: advance, jump back for the second section, or finish
	always_comb begin
		busy_d = busy_q;
		pc_d   = pc_q;
		sec_d  = sec_q;
		if (start) begin
			busy_d = 1'b1;
			pc_d   = '0;
			sec_d  = 1'b0;
		end else if (run) begin
			if (cw.seq_op == SEQ_SEC_END) begin
				pc_d = '0;
				if (sec_q) begin
					busy_d = 1'b0;
				end else begin
					sec_d = 1'b1;
				end
			end else begin
				pc_d = upc_t'(pc_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= '0;
			sec_q  <= 1'b0;
		end else begin
			busy_q <= busy_d;
			pc_q   <= pc_d;
			sec_q  <= sec_d;
		end
	end

	// drive the datapath
	always_comb begin
		ctl.run  = run;
		ctl.sec  = sec_q;
		ctl.emit = run && last;
		ctl.cw   = cw;
	end

	assign busy = busy_q;

`ifndef NO_ASSERTIONS
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> pc_q <= UPC_LAST)
		else $error("step counter beyond end of program");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("word started while sequencer busy");
	a_done_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |=> !busy_q || (pc_q == '0 && !sec_q))
		else $error("sequencer still running after result");
`endif

endmodule

// ===== rtl/bqc_datapath.sv =====
// ----------------------------------------------------------------------------
// bqc_datapath - shared multiply-accumulate datapath
// One coefficient by half-delay-word multiplier, an accumulator, rounding and
// saturation, and the delay words of both sections.
// ----------------------------------------------------------------------------
module bqc_datapath #(
	parameter int SAMPLE_WIDTH = bqc_pkg::SAMPLE_WIDTH_DEF,
	parameter int DELAY_WIDTH  = bqc_pkg::DELAY_WIDTH_DEF,
	parameter int COEF_WIDTH   = bqc_pkg::COEF_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bqc_pkg::bqc_ctl_t            ctl,
	input  logic                         load,
	input  logic [SAMPLE_WIDTH-1:0]      sample,
	input  logic [1:0][COEF_WIDTH-1:0]   fb1,
	input  logic [1:0][COEF_WIDTH-1:0]   fb2,
	input  logic [1:0][3*COEF_WIDTH-1:0] num,
	output logic [SAMPLE_WIDTH-1:0]      y
);
	import bqc_pkg::*;

	localparam int H     = DELAY_WIDTH / 2;
	localparam int OPW   = DELAY_WIDTH - H + 1;
	localparam int PW    = COEF_WIDTH + OPW;
	localparam int BIG   = (SAMPLE_WIDTH + Q_COEF + Q_DELAY > COEF_WIDTH + DELAY_WIDTH) ?
		SAMPLE_WIDTH + Q_COEF + Q_DELAY : COEF_WIDTH + DELAY_WIDTH;
	localparam int ACC_W = BIG + 2;
	localparam int R1W   = ACC_W + 1 - Q_COEF;
	localparam int R2W   = ACC_W + 1 - Q_COEF - Q_DELAY;
	localparam logic [ACC_W:0] RND1 = (ACC_W+1)'(1) << (Q_COEF - 1);
	localparam logic [ACC_W:0] RND2 = (ACC_W+1)'(1) << (Q_COEF + Q_DELAY - 1);

	logic signed [SAMPLE_WIDTH-1:0] x_q;
	logic signed [DELAY_WIDTH-1:0]  d1_q [2];
	logic signed [DELAY_WIDTH-1:0]  d2_q [2];
	logic signed [DELAY_WIDTH-1:0]  w_q;
	logic signed [DELAY_WIDTH-1:0]  mid_q;
	logic signed [ACC_W-1:0]        acc_q;
	logic signed [PW-1:0]           prod_s1;
	logic                           hi_s1;

	logic signed [COEF_WIDTH-1:0]   coef;
	logic signed [DELAY_WIDTH-1:0]  od;
	logic signed [OPW-1:0]          opnd;
	logic signed [PW-1:0]           prod;
	logic signed [ACC_W-1:0]        term_ext;
	logic signed [ACC_W-1:0]        term;
	logic signed [ACC_W-1:0]        load_in;
	logic [ACC_W:0]                 rnd1_sum;
	logic [ACC_W:0]                 rnd2_sum;
	logic [R1W-1:0]                 r1;
	logic [R2W-1:0]                 r2;
	logic signed [DELAY_WIDTH-1:0]  r1_sat;

	// select the coefficient of this section
	always_comb begin
		case (ctl.cw.coef)
			COEF_A1: coef = fb1[ctl.sec];
			COEF_A2: coef = fb2[ctl.sec];
			COEF_B0: coef = num[ctl.sec][COEF_WIDTH-1:0];
			COEF_B1: coef = num[ctl.sec][2*COEF_WIDTH-1:COEF_WIDTH];
			COEF_B2: coef = num[ctl.sec][3*COEF_WIDTH-1:2*COEF_WIDTH];
			default: coef = '0;
		endcase
	end

	// select the delay word and take its low or high half
	always_comb begin
		case (ctl.cw.opnd)
			OPND_W1: od = d1_q[ctl.sec];
			OPND_W2: od = d2_q[ctl.sec];
			OPND_W:  od = w_q;
			default: od = '0;
		endcase
	end

	assign opnd = ctl.cw.mul_hi ?
		{{(OPW-(DELAY_WIDTH-H)){od[DELAY_WIDTH-1]}}, od[DELAY_WIDTH-1:H]} :
		{{(OPW-H){1'b0}}, od[H-1:0]};

	assign prod = coef * opnd;

	// register the partial product with its weight
	always_ff @(posedge clk) begin
		if (ctl.run) begin
			prod_s1 <= prod;
			hi_s1   <= ctl.cw.mul_hi;
		end
	end

	assign term_ext = ACC_W'(prod_s1);
	assign term     = hi_s1 ? (term_ext <<< H) : term_ext;
	assign load_in  = ctl.sec ? (ACC_W'(mid_q) <<< Q_COEF) :
		(ACC_W'(x_q) <<< (Q_COEF + Q_DELAY));

	// round half up and saturate to a delay word
	assign rnd1_sum = {acc_q[ACC_W-1], acc_q} + RND1;
	assign r1       = rnd1_sum[ACC_W:Q_COEF];
	assign r1_sat   = (r1[R1W-1:DELAY_WIDTH-1] == {(R1W-DELAY_WIDTH+1){r1[R1W-1]}}) ?
		r1[DELAY_WIDTH-1:0] : {r1[R1W-1], {(DELAY_WIDTH-1){~r1[R1W-1]}}};

	// round half up to an integer and saturate to a sample
	assign rnd2_sum = {acc_q[ACC_W-1], acc_q} + RND2;
	assign r2       = rnd2_sum[ACC_W:Q_COEF+Q_DELAY];
	assign y        = (r2[R2W-1:SAMPLE_WIDTH-1] == {(R2W-SAMPLE_WIDTH+1){r2[R2W-1]}}) ?
		r2[SAMPLE_WIDTH-1:0] : {r2[R2W-1], {(SAMPLE_WIDTH-1){~r2[R2W-1]}}};

	// capture the input word
	always_ff @(posedge clk) begin
		if (load) begin
			x_q <= sample;
		end
	end

	// accumulate, write the new w, and close a section
	always_ff @(posedge clk) begin
		if (ctl.run) begin
			case (ctl.cw.acc_op)
				ACC_LOAD_IN: acc_q <= load_in;
				ACC_SUB:     acc_q <= acc_q - term;
				ACC_ADD:     acc_q <= acc_q + term;
				ACC_LOAD_P:  acc_q <= term;
				default:     acc_q <= acc_q;
			endcase
			if (ctl.cw.wr_w) begin
				w_q <= r1_sat;
			end
			if (ctl.cw.seq_op == SEQ_SEC_END) begin
				mid_q <= r1_sat;
			end
		end
	end

	// shift the delay line of the current section
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d1_q[0] <= '0;
			d1_q[1] <= '0;
			d2_q[0] <= '0;
			d2_q[1] <= '0;
		end else if (ctl.run && ctl.cw.seq_op == SEQ_SEC_END) begin
			d2_q[ctl.sec] <= d1_q[ctl.sec];
			d1_q[ctl.sec] <= w_q;
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb - self-checking bench for the two-section biquad cascade filter
// Runs a directed table of samples and coefficient writes, then phases of
// random samples under several coefficient sets, with random idle and stall
// bursts on both channels. Every output word is checked against a bit-exact
// fixed-point model of the cascade kept in the bench.
// ----------------------------------------------------------------------------
module tb;
	import bqc_pkg::*;

	localparam int SW = SAMPLE_WIDTH_DEF;
	localparam int DW = DELAY_WIDTH_DEF;
	localparam int CW = COEF_WIDTH_DEF;
	localparam int LATENCY = 25;
	localparam int LIMIT_CYCLES = 200000;
	localparam int N_PHASES = 8;
	localparam int WORDS_PER_PHASE = 50;
	localparam int N_DIRECTED = 34;

	// indexes past the last register: writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_VOID_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_VOID_B = 3'd7;

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;
	typedef enum int {SET_DEFAULT, SET_MILD, SET_WILD, SET_EXTREME} coef_set_t;

	typedef struct packed {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [3*CW-1:0]      data;
		logic [SW-1:0]        smp;
		logic                 typed;
		logic [SW-1:0]        want;
	} row_t;

	// directed table: typed results only after reset, with a zero second-section
	// numerator and with unity pass-through coefficients
	localparam row_t DIRECTED [0:N_DIRECTED-1] = '{
		'{ROW_SAMPLE, '0, '0, 24'h000000, 1'b1, 24'h000000},
		'{ROW_SAMPLE, '0, '0, 24'h7FFFFF, 1'b1, 24'h026000},
		'{ROW_SAMPLE, '0, '0, 24'h800000, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, 24'h000001, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, 24'hFFFFFF, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, 24'h555555, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, 24'hAAAAAA, 1'b0, '0},
		'{ROW_WRITE, REG_SEC0_FB1, {36'hFFFFFFFFF, 18'h20000}, '0, 1'b0, '0},
		'{ROW_WRITE, REG_SEC0_FB2, {36'h0, 18'h1FFFF}, '0, 1'b0, '0},
		'{ROW_WRITE, REG_SEC0_NUM, {3{18'h1FFFF}}, '0, 1'b0, '0},
		'{ROW_WRITE, REG_SEC1_FB1, {36'h0, 18'h1FFFF}, '0, 1'b0, '0},
		'{ROW_WRITE, REG_SEC1_FB2, {36'h0, 18'h20000}, '0, 1'b0, '0},
		'{ROW_WRITE, REG_SEC1_NUM, {3{18'h20000}}, '0, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, 24'h7FFFFF, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, 24'h7FFFFF, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, 24'h7FFFFF, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, 24'h800000, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, 24'h800000, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, 24'h800000, 1'b0, '0},
		'{ROW_WRITE, REG_SEC1_NUM, '0, '0, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, 24'h7FFFFF, 1'b1, 24'h000000},
		'{ROW_SAMPLE, '0, '0, 24'h800000, 1'b1, 24'h000000},
		'{ROW_WRITE, REG_VOID_A, {54{1'b1}}, '0, 1'b0, '0},
		'{ROW_WRITE, REG_VOID_B, {54{1'b1}}, '0, 1'b0, '0},
		'{ROW_WRITE, REG_SEC0_FB1, '0, '0, 1'b0, '0},
		'{ROW_WRITE, REG_SEC0_FB2, '0, '0, 1'b0, '0},
		'{ROW_WRITE, REG_SEC0_NUM, {18'h0, 18'h0, 18'h08000}, '0, 1'b0, '0},
		'{ROW_WRITE, REG_SEC1_FB1, '0, '0, 1'b0, '0},
		'{ROW_WRITE, REG_SEC1_FB2, '0, '0, 1'b0, '0},
		'{ROW_WRITE, REG_SEC1_NUM, {18'h0, 18'h0, 18'h08000}, '0, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, 24'h000800, 1'b1, 24'h000800},
		'{ROW_SAMPLE, '0, '0, 24'hFFF800, 1'b1, 24'hFFF800},
		'{ROW_SAMPLE, '0, '0, 24'h7FFFFF, 1'b1, 24'h7FFFFF},
		'{ROW_SAMPLE, '0, '0, 24'h800000, 1'b1, 24'h800000}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [SW-1:0]        sample_in = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [SW-1:0]        sample_out;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [3*CW-1:0]      cfg_data = '0;

	// bench copy of the coefficients and of the delay lines
	logic [3*CW-1:0] coef_reg [6];
	longint          dly_w1 [2];
	longint          dly_w2 [2];

	logic [SW-1:0] pending_out [$];
	int            mismatches = 0;
	int            cycle_cnt = 0;
	int            gap_pct = 0;
	int            stall_pct = 0;
	int            stall_left = 0;

	iir_biquad_cascade_filter_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// round half up, then clamp to a signed width
	function automatic longint round_clamp(longint acc, int shift, int width);
		longint r;
		longint hi;
		r = (acc + (longint'(1) <<< (shift - 1))) >>> shift;
		hi = (longint'(1) <<< (width - 1)) - 1;
		if (r > hi)
			return hi;
		if (r < -hi - 1)
			return -hi - 1;
		return r;
	endfunction

	// one direct-form-II section; returns the unrounded Q.27 output sum
	function automatic longint run_biquad(int sec, logic [CFG_IDX_W-1:0] fb1_i,
			logic [CFG_IDX_W-1:0] fb2_i, logic [CFG_IDX_W-1:0] num_i, longint x);
		longint a1, a2, b0, b1, b2, acc, w;
		logic [3*CW-1:0] num;
		num = coef_reg[num_i];
		a1 = longint'($signed(coef_reg[fb1_i][CW-1:0]));
		a2 = longint'($signed(coef_reg[fb2_i][CW-1:0]));
		b0 = longint'($signed(num[CW-1:0]));
		b1 = longint'($signed(num[2*CW-1:CW]));
		b2 = longint'($signed(num[3*CW-1:2*CW]));
		acc = (x <<< Q_COEF) - a1 * dly_w1[sec] - a2 * dly_w2[sec];
		w = round_clamp(acc, Q_COEF, DW);
		acc = b0 * w + b1 * dly_w1[sec] + b2 * dly_w2[sec];
		dly_w2[sec] = dly_w1[sec];
		dly_w1[sec] = w;
		return acc;
	endfunction

	function automatic logic [SW-1:0] filter_sample(logic [SW-1:0] s);
		longint x;
		longint mid;
		x = longint'($signed(s)) <<< Q_DELAY;
		mid = round_clamp(run_biquad(0, REG_SEC0_FB1, REG_SEC0_FB2, REG_SEC0_NUM, x),
			Q_COEF, DW);
		return SW'(round_clamp(run_biquad(1, REG_SEC1_FB1, REG_SEC1_FB2, REG_SEC1_NUM,
			mid), Q_COEF + Q_DELAY, SW));
	endfunction

	function automatic logic [CW-1:0] coef_field(coef_set_t m, int span);
		case (m)
			SET_MILD: return CW'(int'($urandom_range(0, 2 << span)) - (1 << span));
			SET_EXTREME: begin
				case ($urandom_range(0, 2))
					0: return 18'h20000;
					1: return 18'h1FFFF;
					default: return '0;
				endcase
			end
			default: return CW'($urandom);
		endcase
	endfunction

	// feedback word with junk above the field, which the block must drop
	function automatic logic [3*CW-1:0] fb_word(coef_set_t m, int span);
		logic [63:0] junk;
		junk = {$urandom, $urandom};
		return {junk[3*CW-1:CW], coef_field(m, span)};
	endfunction

	function automatic logic [3*CW-1:0] num_word(coef_set_t m);
		return {coef_field(m, 15), coef_field(m, 15), coef_field(m, 15)};
	endfunction

	function automatic logic [SW-1:0] next_sample();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return SW'($urandom);
			4, 5, 6: return SW'(int'($urandom_range(0, 8191)) - 4096);
			7: return 24'h7FFFFF;
			8: return 24'h800000;
			default: return SW'($urandom_range(0, 255));
		endcase
	endfunction

	// write one register; the caller lowers the enable later
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [3*CW-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		if (idx <= REG_SEC1_NUM)
			coef_reg[idx] = data;
	endtask

	// offer one word and hold it until taken
	task automatic send_sample(logic [SW-1:0] s, logic typed, logic [SW-1:0] want);
		logic [SW-1:0] pred;
		cfg_we <= 1'b0;
		in_valid <= 1'b1;
		sample_in <= s;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		pred = filter_sample(s);
		pending_out.push_back(typed ? want : pred);
	endtask

	task automatic idle_in(int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// drop valid and wait for every outstanding word
	task automatic settle_out();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_out.size() != 0);
	endtask

	task automatic load_coefs(coef_set_t m);
		settle_out();
		if (m == SET_DEFAULT) begin
			write_reg(REG_SEC0_FB1, RST_SEC0_FB1[3*CW-1:0]);
			write_reg(REG_SEC0_FB2, RST_SEC0_FB2[3*CW-1:0]);
			write_reg(REG_SEC0_NUM, RST_SEC0_NUM[3*CW-1:0]);
			write_reg(REG_SEC1_FB1, RST_SEC1_FB1[3*CW-1:0]);
			write_reg(REG_SEC1_FB2, RST_SEC1_FB2[3*CW-1:0]);
			write_reg(REG_SEC1_NUM, RST_SEC1_NUM[3*CW-1:0]);
		end else begin
			write_reg(REG_SEC0_FB1, fb_word(m, 14));
			write_reg(REG_SEC0_FB2, fb_word(m, 13));
			write_reg(REG_SEC0_NUM, num_word(m));
			write_reg(REG_SEC1_FB1, fb_word(m, 14));
			write_reg(REG_SEC1_FB2, fb_word(m, 13));
			write_reg(REG_SEC1_NUM, num_word(m));
		end
		if ($urandom_range(0, 1) == 0)
			write_reg($urandom_range(0, 1) ? REG_VOID_A : REG_VOID_B,
				(3*CW)'({$urandom, $urandom}));
	endtask

	// receiver stall bursts
	always @(posedge clk) begin
		if (stall_left != 0)
			stall_left--;
		else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
			stall_left = $urandom_range(1, 7);
		out_stall <= (stall_left != 0);
	end

	// check each accepted output word against the oldest expectation
	always @(posedge clk) begin
		logic [SW-1:0] want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_out.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected sample_out %h", sample_out);
				mismatches++;
			end else begin
				want = pending_out.pop_front();
				if (sample_out !== want) begin
					if (mismatches < 10)
						$display("sample_out mismatch: expected %h, got %h", want, sample_out);
					mismatches++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > LIMIT_CYCLES) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		coef_set_t m;
		coef_reg[REG_SEC0_FB1] = RST_SEC0_FB1[3*CW-1:0];
		coef_reg[REG_SEC0_FB2] = RST_SEC0_FB2[3*CW-1:0];
		coef_reg[REG_SEC0_NUM] = RST_SEC0_NUM[3*CW-1:0];
		coef_reg[REG_SEC1_FB1] = RST_SEC1_FB1[3*CW-1:0];
		coef_reg[REG_SEC1_FB2] = RST_SEC1_FB2[3*CW-1:0];
		coef_reg[REG_SEC1_NUM] = RST_SEC1_NUM[3*CW-1:0];
		dly_w1 = '{0, 0};
		dly_w2 = '{0, 0};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		for (int r = 0; r < N_DIRECTED; r++) begin
			if (DIRECTED[r].kind == ROW_WRITE) begin
				settle_out();
				write_reg(DIRECTED[r].idx, DIRECTED[r].data);
			end else begin
				send_sample(DIRECTED[r].smp, DIRECTED[r].typed, DIRECTED[r].want);
			end
		end

		// random phases, each under its own coefficient set
		for (int p = 0; p < N_PHASES; p++) begin
			m = (p < 4) ? coef_set_t'(p) : coef_set_t'($urandom_range(0, 3));
			if (p == N_PHASES - 1) begin
				gap_pct = 0;
				stall_pct = 0;
			end else begin
				case ($urandom_range(0, 2))
					0: gap_pct = 0;
					1: gap_pct = 15;
					default: gap_pct = 40;
				endcase
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 15;
					default: stall_pct = 40;
				endcase
			end
			load_coefs(m);
			repeat (WORDS_PER_PHASE) begin
				if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
					idle_in($urandom_range(1, 7));
				if (p != N_PHASES - 1 && $urandom_range(0, 59) == 0)
					settle_out();
				send_sample(next_sample(), 1'b0, '0);
			end
		end

		// drain and let the pipeline go quiet
		settle_out();
		repeat (2 * LATENCY) @(posedge clk);
		if (mismatches == 0 && pending_out.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/bqc_pkg.sv
rtl/bqc_regs.sv
rtl/bqc_useq.sv
rtl/bqc_datapath.sv
rtl/iir_biquad_cascade_filter_top.sv
tb/sv/tb.sv
